### sv/tcc_pkg.sv
package tcc_pkg;

  // Default geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Widest command fields the geometry range can need
  localparam int CMD_ROW_W = 7;
  localparam int CMD_COL_W = 8;
  localparam int CMD_OFF_W = 15;

  localparam int QUEUE_DEPTH = 2;

  // Item kinds
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // Control characters
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_BLANK     = 8'd32;

  // Configuration register indexes
  localparam logic [1:0] REG_TEXT_ATTR     = 2'd0;
  localparam logic [1:0] REG_SCROLL_TOP    = 2'd1;
  localparam logic [1:0] REG_SCROLL_BOTTOM = 2'd2;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_SETCUR,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [7:0]           ch;
    logic [CMD_ROW_W-1:0] row;
    logic [CMD_COL_W-1:0] col;
    logic [CMD_OFF_W-1:0] off;
    logic                 valid;
  } cmd_t;

  typedef struct packed {
    logic [7:0] attr;
    logic [4:0] top;
    logic [4:0] bottom;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_offset;
    logic [15:0] cell_data;
    logic        cell_valid;
  } res_t;

endpackage

### sv/tcc_ram.sv
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/tcc_fifo.sv
module tcc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

### sv/tcc_front.sv
module tcc_front #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  logic               [1:0] kind,
  input  logic               [7:0] char_code,
  input  logic signed        [8:0] row,
  input  logic signed        [8:0] col,
  output tcc_pkg::cmd_t            cmd
);

  import tcc_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam int AW = $clog2(ROWS * COLUMNS);

  logic          row_big;
  logic          col_big;
  logic [RW-1:0] row_c;
  logic [CW-1:0] col_c;
  logic [AW-1:0] off;

  // Clamp to the screen; a read's result is valid only when it was inside
  always_comb begin
    row_big = !row[8] && ({1'b0, row[7:0]} >= 9'(ROWS));
    col_big = !col[8] && ({1'b0, col[7:0]} >= 9'(COLUMNS));
    if (row[8]) begin
      row_c = '0;
    end else if (row_big) begin
      row_c = RW'(ROWS - 1);
    end else begin
      row_c = row[RW-1:0];
    end
    if (col[8]) begin
      col_c = '0;
    end else if (col_big) begin
      col_c = CW'(COLUMNS - 1);
    end else begin
      col_c = col[CW-1:0];
    end
    off = AW'(row_c) * AW'(COLUMNS) + AW'(col_c);
  end

  always_comb begin
    cmd.ch    = char_code;
    cmd.row   = CMD_ROW_W'(row_c);
    cmd.col   = CMD_COL_W'(col_c);
    cmd.off   = CMD_OFF_W'(off);
    cmd.valid = !row[8] && !row_big && !col[8] && !col_big;
    case (kind)
      KIND_PUT: begin
        case (char_code)
          CH_NEWLINE:   cmd.op = OP_NEWLINE;
          CH_RETURN:    cmd.op = OP_RETURN;
          CH_BACKSPACE: cmd.op = OP_BACKSPACE;
          default:      cmd.op = OP_PRINT;
        endcase
      end
      KIND_SET:   cmd.op = OP_SETCUR;
      KIND_CLEAR: cmd.op = OP_CLEAR;
      KIND_READ:  cmd.op = OP_READ;
      default:    cmd.op = OP_READ;
    endcase
  end

endmodule

### sv/tcc_back.sv
module tcc_back #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  tcc_pkg::cfg_t cfg,
  input  logic          cmd_empty,
  input  tcc_pkg::cmd_t cmd_head,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output tcc_pkg::res_t res,
  output logic          init_busy
);

  import tcc_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam int N  = ROWS * COLUMNS;
  localparam int AW = $clog2(N);
  localparam int NW = $clog2(N + 1);

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_EXEC = 6'b000100,
    S_MOVE = 6'b001000,
    S_FILL = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t        state;
  cmd_t          cmd;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [AW-1:0] cur_off;
  logic [NW-1:0] ptr;
  logic [NW-1:0] ptr_end;
  logic [15:0]   fill_data;
  logic          wr_pend;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] reg_top;
  logic [RW-1:0] reg_bot;
  logic [NW-1:0] top_off;
  logic [NW-1:0] bot_off;
  logic          region_bad;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  logic          wrap;
  logic          at_bot;
  logic          bs_move;
  logic [15:0]   blank;

  // Region follows the registers; an invalid pair means the full screen
  assign region_bad = (cfg.top > cfg.bottom) || (int'(cfg.top) >= ROWS)
                      || (int'(cfg.bottom) >= ROWS);

  always_ff @(posedge clk) begin
    reg_top <= region_bad ? '0 : RW'(cfg.top);
    reg_bot <= region_bad ? RW'(ROWS - 1) : RW'(cfg.bottom);
    top_off <= region_bad ? '0 : NW'(cfg.top) * NW'(COLUMNS);
    bot_off <= region_bad ? NW'((ROWS - 1) * COLUMNS) : NW'(cfg.bottom) * NW'(COLUMNS);
  end

  assign blank   = {cfg.attr, CH_BLANK};
  assign wrap    = (cmd.op == OP_NEWLINE)
                   || ((cmd.op == OP_PRINT) && (cur_col == CW'(COLUMNS - 1)));
  assign at_bot  = (cur_row >= reg_bot);
  assign bs_move = (cur_col != '0) || (cur_row > reg_top);

  assign cmd_pop   = (state == S_IDLE) && !cmd_empty && !res_full;
  assign res_push  = (state == S_DONE);
  assign init_busy = (state == S_INIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      ptr     <= '0;
      ptr_end <= NW'(N);
      cur_row <= '0;
      cur_col <= '0;
      cur_off <= '0;
      wr_pend <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          ptr <= ptr + NW'(1);
          if (ptr + NW'(1) == ptr_end) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_pop) begin
            cmd   <= cmd_head;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          case (cmd.op)
            OP_PRINT, OP_NEWLINE: begin
              if (wrap) begin
                cur_col <= '0;
                if (at_bot) begin
                  cur_row <= reg_bot;
                  cur_off <= AW'(bot_off);
                  if (reg_top < reg_bot) begin
                    ptr       <= top_off + NW'(COLUMNS);
                    ptr_end   <= bot_off + NW'(COLUMNS);
                    wr_pend   <= 1'b0;
                    fill_data <= blank;
                    state     <= S_MOVE;
                  end
                end else begin
                  cur_row <= cur_row + RW'(1);
                  cur_off <= cur_off - AW'(cur_col) + AW'(COLUMNS);
                end
              end else begin
                cur_col <= cur_col + CW'(1);
                cur_off <= cur_off + AW'(1);
              end
            end
            OP_RETURN: begin
              cur_col <= '0;
              cur_off <= cur_off - AW'(cur_col);
            end
            OP_BACKSPACE: begin
              if (cur_col != '0) begin
                cur_col <= cur_col - CW'(1);
                cur_off <= cur_off - AW'(1);
              end else if (cur_row > reg_top) begin
                cur_row <= cur_row - RW'(1);
                cur_col <= CW'(COLUMNS - 1);
                cur_off <= cur_off - AW'(1);
              end
            end
            OP_SETCUR: begin
              cur_row <= RW'(cmd.row);
              cur_col <= CW'(cmd.col);
              cur_off <= AW'(cmd.off);
            end
            OP_CLEAR: begin
              cur_row   <= '0;
              cur_col   <= '0;
              cur_off   <= '0;
              ptr       <= '0;
              ptr_end   <= NW'(N);
              fill_data <= blank;
              state     <= S_FILL;
            end
            default: begin
            end
          endcase
        end
        S_MOVE: begin
          if (ptr != ptr_end) begin
            ptr     <= ptr + NW'(1);
            wr_pend <= 1'b1;
            wr_addr <= AW'(ptr - NW'(COLUMNS));
          end else begin
            wr_pend <= 1'b0;
            ptr     <= bot_off;
            ptr_end <= bot_off + NW'(COLUMNS);
            state   <= S_FILL;
          end
        end
        S_FILL: begin
          ptr <= ptr + NW'(1);
          if (ptr + NW'(1) == ptr_end) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Cell store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_off;
    ram_wdata = blank;
    ram_re    = 1'b0;
    ram_raddr = AW'(cmd.off);
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr[AW-1:0];
        ram_wdata = '0;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr[AW-1:0];
        ram_wdata = fill_data;
      end
      S_MOVE: begin
        ram_we    = wr_pend;
        ram_waddr = wr_addr;
        ram_wdata = ram_rdata;
        ram_re    = (ptr != ptr_end);
        ram_raddr = ptr[AW-1:0];
      end
      S_EXEC: begin
        case (cmd.op)
          OP_PRINT: begin
            ram_we    = 1'b1;
            ram_wdata = {cfg.attr, cmd.ch};
          end
          OP_BACKSPACE: begin
            ram_we    = bs_move;
            ram_waddr = cur_off - AW'(1);
          end
          OP_READ: begin
            ram_re = cmd.valid;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  tcc_ram #(
    .WIDTH(16),
    .DEPTH(N)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    res.cursor_row    = 5'(cur_row);
    res.cursor_col    = 7'(cur_col);
    res.cursor_offset = 11'(cur_off);
    res.cell_valid    = (cmd.op == OP_READ) && cmd.valid;
    res.cell_data     = res.cell_valid ? ram_rdata : '0;
  end

  a_offset_tracks: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |->
      (cur_off == AW'(AW'(cur_row) * AW'(COLUMNS) + AW'(cur_col))))
    else $error("cursor offset out of step with row and column");

  a_result_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> !res_full)
    else $error("result queue filled while a command was in flight");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && cmd.op == OP_READ) |=> (state == S_DONE))
    else $error("read result not presented the cycle after the read");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL || state == S_INIT) |-> (ptr < ptr_end))
    else $error("fill sweep ran past its end");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> ((int'(cur_row) < ROWS) && (int'(cur_col) < COLUMNS)))
    else $error("cursor left the screen");

endmodule

### sv/text_console_cell_engine.sv
// Text console over a ROWS x COLUMNS store of 16-bit cells (character in the
// low byte, attribute in the high byte). Items enter through a queue-style
// push/full port and each yields exactly one result beat on the empty/pop
// side, in order. After reset the cell store is swept to zero, one cell a
// cycle, over all ROWS*COLUMNS cells (2000 at the default 80x25), with full
// held high; configuration writes are taken throughout. The back end runs
// one item at a time and owns the dual-port cell RAM: a printable character,
// return, backspace, set cursor or read steps through execute and done; a
// newline or wrap that scrolls also moves the region up a row and blanks
// its bottom row, and a clear blanks the whole store. The front end decodes
// and clamps an item in the cycle it is accepted, so two queued items can
// wait while the back end is busy, and two finished results can wait to be
// popped; while both wait, the back end takes no new item.
module text_console_cell_engine #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // item side
  input  logic              push,
  input  logic       [1:0]  kind,
  input  logic       [7:0]  char_code,
  input  logic signed [8:0] row,
  input  logic signed [8:0] col,
  output logic              full,
  // result side
  output logic              empty,
  input  logic              pop,
  output logic       [4:0]  cursor_row,
  output logic       [6:0]  cursor_col,
  output logic       [10:0] cursor_offset,
  output logic       [15:0] cell_data,
  output logic              cell_valid,
  // configuration
  input  logic              cfg_write,
  input  logic       [1:0]  cfg_index,
  input  logic       [7:0]  cfg_data
);

  import tcc_pkg::*;

  cfg_t cfg;
  cmd_t cmd_in;
  cmd_t cmd_head;
  res_t res_in;
  res_t res_head;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  logic init_busy;

  // Configuration registers; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attr   <= 8'd15;
      cfg.top    <= 5'd0;
      cfg.bottom <= 5'd24;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEXT_ATTR:     cfg.attr   <= cfg_data;
        REG_SCROLL_TOP:    cfg.top    <= cfg_data[4:0];
        REG_SCROLL_BOTTOM: cfg.bottom <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Hold off new beats while the store is being swept after reset
  assign full = cmd_full || init_busy;

  // Decode, clamp and address an item as it is accepted
  tcc_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .kind     (kind),
    .char_code(char_code),
    .row      (row),
    .col      (col),
    .cmd      (cmd_in)
  );

  // Decoupling queue between decode and execution
  tcc_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && !init_busy),
    .wdata(cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_head),
    .empty(cmd_empty)
  );

  // Execute commands against the cell store and the cursor
  tcc_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_empty(cmd_empty),
    .cmd_head (cmd_head),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in),
    .init_busy(init_busy)
  );

  // Result queue: finished beats wait here until popped
  tcc_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_head),
    .empty(empty)
  );

  assign cursor_row    = res_head.cursor_row;
  assign cursor_col    = res_head.cursor_col;
  assign cursor_offset = res_head.cursor_offset;
  assign cell_data     = res_head.cell_data;
  assign cell_valid    = res_head.cell_valid;

endmodule

### bench/console_checker.sv
module console_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic       [1:0]  kind,
  input  logic       [7:0]  char_code,
  input  logic signed [8:0] row,
  input  logic signed [8:0] col,
  input  logic              full,
  input  logic              empty,
  input  logic              pop,
  input  logic       [4:0]  cursor_row,
  input  logic       [6:0]  cursor_col,
  input  logic       [10:0] cursor_offset,
  input  logic       [15:0] cell_data,
  input  logic              cell_valid,
  input  logic              cfg_write,
  input  logic       [1:0]  cfg_index,
  input  logic       [7:0]  cfg_data,
  output int                errors,
  output int                pending,
  output int                checked
);

  import tcc_pkg::*;

  localparam int NCELLS    = COLUMNS_DEF * ROWS_DEF;
  localparam int PRINT_CAP = 100;

  // Shadow of the console: cell store, cursor and register copies
  logic [15:0] cells [0:NCELLS-1];
  int          crow;
  int          ccol;
  logic [7:0]  attr_reg;
  logic [4:0]  top_reg;
  logic [4:0]  bot_reg;

  res_t cursor_results [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < PRINT_CAP)
      $display("checker: beat %0d %s: got %0d, want %0d", checked, what, got, want);
    errors++;
  endtask

  task automatic region_bounds(output int t, output int b);
    if (top_reg > bot_reg || top_reg >= ROWS_DEF || bot_reg >= ROWS_DEF) begin
      t = 0;
      b = ROWS_DEF - 1;
    end else begin
      t = top_reg;
      b = bot_reg;
    end
  endtask

  // Move to the start of the next row, scrolling the region when passing its bottom
  task automatic advance_row();
    int t, b;
    ccol = 0;
    crow++;
    region_bounds(t, b);
    if (crow > b) begin
      if (t < b) begin
        for (int i = t * COLUMNS_DEF; i < b * COLUMNS_DEF; i++)
          cells[i] = cells[i + COLUMNS_DEF];
        for (int x = 0; x < COLUMNS_DEF; x++)
          cells[b * COLUMNS_DEF + x] = {attr_reg, CH_BLANK};
      end
      crow = b;
    end
  endtask

  task automatic apply_item(input logic [1:0] k, input logic [7:0] ch,
                            input logic signed [8:0] r_in, input logic signed [8:0] c_in,
                            output res_t res);
    int t, b, rr, cc;
    logic [15:0] data;
    logic        valid;
    data  = '0;
    valid = 1'b0;
    rr    = r_in;
    cc    = c_in;
    case (k)
      KIND_PUT: begin
        if (ch == CH_NEWLINE) begin
          advance_row();
        end else if (ch == CH_RETURN) begin
          ccol = 0;
        end else if (ch == CH_BACKSPACE) begin
          region_bounds(t, b);
          if (ccol > 0) begin
            ccol--;
            cells[crow * COLUMNS_DEF + ccol] = {attr_reg, CH_BLANK};
          end else if (crow > t) begin
            crow--;
            ccol = COLUMNS_DEF - 1;
            cells[crow * COLUMNS_DEF + ccol] = {attr_reg, CH_BLANK};
          end
        end else begin
          cells[crow * COLUMNS_DEF + ccol] = {attr_reg, ch};
          ccol++;
          if (ccol >= COLUMNS_DEF) advance_row();
        end
      end
      KIND_SET: begin
        if (rr < 0) rr = 0;
        else if (rr >= ROWS_DEF) rr = ROWS_DEF - 1;
        if (cc < 0) cc = 0;
        else if (cc >= COLUMNS_DEF) cc = COLUMNS_DEF - 1;
        crow = rr;
        ccol = cc;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < NCELLS; i++) cells[i] = {attr_reg, CH_BLANK};
        crow = 0;
        ccol = 0;
      end
      default: begin
        if (rr >= 0 && rr < ROWS_DEF && cc >= 0 && cc < COLUMNS_DEF) begin
          data  = cells[rr * COLUMNS_DEF + cc];
          valid = 1'b1;
        end
      end
    endcase
    res.cursor_row    = crow[4:0];
    res.cursor_col    = ccol[6:0];
    res.cursor_offset = 11'(crow * COLUMNS_DEF + ccol);
    res.cell_data     = data;
    res.cell_valid    = valid;
  endtask

  always @(posedge clk) begin : watch
    res_t want, got;
    if (rst) begin
      for (int i = 0; i < NCELLS; i++) cells[i] = '0;
      crow     = 0;
      ccol     = 0;
      attr_reg = 8'd15;
      top_reg  = 5'd0;
      bot_reg  = 5'd24;
      cursor_results.delete();
      errors   = 0;
      checked  = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TEXT_ATTR:     attr_reg = cfg_data;
          REG_SCROLL_TOP:    top_reg  = cfg_data[4:0];
          REG_SCROLL_BOTTOM: bot_reg  = cfg_data[4:0];
          default: ;
        endcase
      end
      // result side first, so a beat never meets an item taken on the same edge
      if (pop && !empty) begin
        got.cursor_row    = cursor_row;
        got.cursor_col    = cursor_col;
        got.cursor_offset = cursor_offset;
        got.cell_data     = cell_data;
        got.cell_valid    = cell_valid;
        if (cursor_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", 1, 0);
        end else begin
          want = cursor_results.pop_front();
          if (got.cursor_row != want.cursor_row)
            report_mismatch("cursor_row", got.cursor_row, want.cursor_row);
          if (got.cursor_col != want.cursor_col)
            report_mismatch("cursor_col", got.cursor_col, want.cursor_col);
          if (got.cursor_offset != want.cursor_offset)
            report_mismatch("cursor_offset", got.cursor_offset, want.cursor_offset);
          if (got.cell_data != want.cell_data)
            report_mismatch("cell_data", got.cell_data, want.cell_data);
          if (got.cell_valid != want.cell_valid)
            report_mismatch("cell_valid", got.cell_valid, want.cell_valid);
        end
        checked++;
      end
      if (push && !full) begin
        apply_item(kind, char_code, row, col, want);
        cursor_results.push_back(want);
      end
    end
    pending = cursor_results.size();
  end

endmodule

### bench/tb_top.sv
module tb_top;
  import tcc_pkg::*;

  // Give up well beyond the slowest legal run: every item a full-screen
  // scroll or clear, each beat stalled to the limit, plus the reset sweep.
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int PHASES        = 6;
  localparam int ITEMS_A_PHASE = 87;

  // Unused register index: the block must ignore writes to it
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Stall styles of the result side
  localparam int POP_ALWAYS = 0;
  localparam int POP_JITTER = 1;
  localparam int POP_LONG   = 2;

  logic              clk;
  logic              rst;
  logic              push;
  logic       [1:0]  kind;
  logic       [7:0]  char_code;
  logic signed [8:0] row;
  logic signed [8:0] col;
  logic              full;
  logic              empty;
  logic              pop;
  logic       [4:0]  cursor_row;
  logic       [6:0]  cursor_col;
  logic       [10:0] cursor_offset;
  logic       [15:0] cell_data;
  logic              cell_valid;
  logic              cfg_write;
  logic       [1:0]  cfg_index;
  logic       [7:0]  cfg_data;

  int errors;
  int pending;
  int checked;

  int cycle_count = 0;
  int items_sent  = 0;
  int settings    = 0;
  int burst_left  = 0;

  // Our own copy of the region registers, used only to steer the cursor
  logic [4:0] reg_top = 5'd0;
  logic [4:0] reg_bot = 5'd24;

  text_console_cell_engine dut (.*);
  console_checker          chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top: timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending);
    $display("tb_top: done, errors");
    $finish;
  end

  // Result side: pick a stall style for a random span of cycles, then
  // hold pop low for short or long stretches according to that style.
  initial begin : result_side
    int hold, mode, span;
    pop  = 1'b0;
    hold = 0;
    mode = POP_ALWAYS;
    span = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = $urandom_range(POP_ALWAYS, POP_LONG);
        span = $urandom_range(50, 300);
      end
      span--;
      if (hold > 0) begin
        pop = 1'b0;
        hold--;
      end else begin
        pop = 1'b1;
        if (mode == POP_JITTER && $urandom_range(0, 3) == 0)
          hold = $urandom_range(1, 3);
        else if (mode == POP_LONG && $urandom_range(0, 7) == 0)
          hold = $urandom_range(4, 20);
      end
    end
  end

  // Offer one item and hold it until the block takes it. Items go out in
  // bursts; at the end of a burst drop push for a random gap, or carry
  // straight on when the gap comes out as zero.
  task automatic send_item(input logic [1:0] k, input logic [7:0] ch,
                           input int r, input int c);
    int gap;
    kind      = k;
    char_code = ch;
    row       = r[8:0];
    col       = c[8:0];
    push      = 1'b1;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    @(negedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        push = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Stop offering and wait until every result beat has been collected
  task automatic settle();
    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_SCROLL_TOP) reg_top = data[4:0];
    if (idx == REG_SCROLL_BOTTOM) reg_bot = data[4:0];
  endtask

  // One random item. Most are characters; the cursor is often parked near
  // the end of the region's bottom row so that wraps and scrolls happen.
  task automatic random_item();
    int sel, r, c, eff_bot;
    logic [7:0] ch;
    logic [1:0] k;
    if (reg_top > reg_bot || reg_top >= ROWS_DEF || reg_bot >= ROWS_DEF)
      eff_bot = ROWS_DEF - 1;
    else
      eff_bot = reg_bot;
    r  = $urandom_range(0, 511) - 256;
    c  = $urandom_range(0, 511) - 256;
    ch = 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      k   = KIND_PUT;
      sel = $urandom_range(0, 99);
      if (sel < 45)      ch = 8'($urandom_range(32, 126));
      else if (sel < 57) ch = CH_NEWLINE;
      else if (sel < 62) ch = CH_RETURN;
      else if (sel < 72) ch = CH_BACKSPACE;
    end else if (sel < 81) begin
      k   = KIND_SET;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        r = eff_bot;
        c = $urandom_range(60, COLUMNS_DEF - 1);
      end else if (sel < 70) begin
        r = $urandom_range(0, ROWS_DEF - 1);
        c = $urandom_range(0, COLUMNS_DEF - 1);
      end
    end else if (sel < 97) begin
      k = KIND_READ;
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, ROWS_DEF - 1);
        c = $urandom_range(0, COLUMNS_DEF - 1);
      end
    end else begin
      k = KIND_CLEAR;
    end
    send_item(k, ch, r, c);
  endtask

  initial begin : stimulus
    logic [2:0] junk;
    push      = 1'b0;
    kind      = KIND_PUT;
    char_code = 8'd0;
    row       = '0;
    col       = '0;
    cfg_write = 1'b0;
    cfg_index = REG_TEXT_ATTR;
    cfg_data  = 8'd0;
    rst       = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, reset settings: attribute 0x0F, whole screen scrolls.
    // The store is still being swept; push waits on full.
    send_item(KIND_READ, 8'd0, 0, 0);
    send_item(KIND_READ, 8'd0, 24, 79);
    send_item(KIND_READ, 8'd0, -256, 255);          // outside the screen
    send_item(KIND_READ, 8'd0, 25, 80);
    send_item(KIND_SET, 8'd0, -256, -256);          // clamp to the top left
    send_item(KIND_SET, 8'd0, 255, 255);            // clamp to the bottom right
    send_item(KIND_PUT, "A", 0, 0);                 // wrap at the corner scrolls
    send_item(KIND_READ, 8'd0, 23, 79);
    send_item(KIND_PUT, CH_BACKSPACE, 0, 0);        // step back over the row edge
    send_item(KIND_PUT, 8'hFF, 0, 0);
    send_item(KIND_PUT, 8'h00, 0, 0);
    send_item(KIND_PUT, CH_RETURN, 0, 0);
    send_item(KIND_PUT, CH_NEWLINE, 0, 0);
    send_item(KIND_CLEAR, 8'd0, 0, 0);
    send_item(KIND_PUT, CH_BACKSPACE, 0, 0);        // at the region top: no effect
    settle();

    // Single-row region: moving past it pins the row and nothing scrolls
    write_reg(REG_TEXT_ATTR, 8'hA5);
    write_reg(REG_SCROLL_TOP, 8'd5);
    write_reg(REG_SCROLL_BOTTOM, 8'd5);
    settings++;
    send_item(KIND_SET, 8'd0, 5, 79);
    send_item(KIND_PUT, "x", 0, 0);
    send_item(KIND_SET, 8'd0, 20, 3);
    send_item(KIND_PUT, CH_NEWLINE, 0, 0);          // cursor below the region
    settle();

    // Proper region: scroll rows 3 to 10 only
    write_reg(REG_TEXT_ATTR, 8'hF0);
    write_reg(REG_SCROLL_TOP, 8'd3);
    write_reg(REG_SCROLL_BOTTOM, 8'd10);
    settings++;
    send_item(KIND_SET, 8'd0, 20, 10);
    send_item(KIND_PUT, CH_NEWLINE, 0, 0);
    send_item(KIND_SET, 8'd0, 3, 0);
    send_item(KIND_PUT, CH_BACKSPACE, 0, 0);
    send_item(KIND_SET, 8'd0, 4, 0);
    send_item(KIND_PUT, CH_BACKSPACE, 0, 0);
    send_item(KIND_READ, 8'd0, 10, 0);
    settle();

    // Top above bottom falls back to the whole screen
    write_reg(REG_SCROLL_TOP, 8'd20);
    write_reg(REG_SCROLL_BOTTOM, 8'd4);
    settings++;
    send_item(KIND_SET, 8'd0, 24, 0);
    send_item(KIND_PUT, CH_NEWLINE, 0, 0);
    send_item(KIND_READ, 8'd0, 0, 0);
    settle();

    // Random part: a fresh register setting per phase, extremes first
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      junk = 3'($urandom_range(0, 7));
      case (phase)
        0: begin
          write_reg(REG_TEXT_ATTR, 8'h00);
          write_reg(REG_SCROLL_TOP, 8'd0);
          write_reg(REG_SCROLL_BOTTOM, 8'd24);
        end
        1: begin
          write_reg(REG_TEXT_ATTR, 8'hFF);
          write_reg(REG_SCROLL_TOP, 8'd24);
          write_reg(REG_SCROLL_BOTTOM, 8'd24);
        end
        2: begin
          write_reg(REG_TEXT_ATTR, 8'($urandom_range(0, 255)));
          write_reg(REG_SCROLL_TOP, 8'd0);
          write_reg(REG_SCROLL_BOTTOM, 8'd0);
        end
        3: begin
          write_reg(REG_TEXT_ATTR, 8'($urandom_range(0, 255)));
          write_reg(REG_SCROLL_TOP, 8'($urandom_range(0, 24)));
          write_reg(REG_SCROLL_BOTTOM, 8'($urandom_range(0, 24)));
        end
        4: begin
          // upper data bits are junk: the region registers keep the low five
          write_reg(REG_TEXT_ATTR, 8'($urandom_range(0, 255)));
          write_reg(REG_SCROLL_TOP, {junk, 5'($urandom_range(0, 12))});
          write_reg(REG_SCROLL_BOTTOM, {~junk, 5'($urandom_range(12, 24))});
        end
        default: begin
          write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
          write_reg(REG_TEXT_ATTR, 8'($urandom_range(0, 255)));
          write_reg(REG_SCROLL_TOP, 8'($urandom_range(0, 255)));
          write_reg(REG_SCROLL_BOTTOM, 8'($urandom_range(0, 255)));
        end
      endcase
      settings++;
      repeat (ITEMS_A_PHASE) random_item();
    end

    // Drain, then let a few more cycles pass to catch stray beats
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("tb_top: %0d items over %0d register settings, %0d result beats checked",
             items_sent, settings + 1, checked);
    $display("tb_top: covered clamping, wraps, region scrolls, backspace and clears");
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
sv/tcc_pkg.sv
sv/tcc_ram.sv
sv/tcc_fifo.sv
sv/tcc_front.sv
sv/tcc_back.sv
sv/text_console_cell_engine.sv
bench/console_checker.sv
bench/tb_top.sv
